// File: src/uft_pkg.sv
// Shared types, constants and sizes for the upstream failure tracker.
`default_nettype none
package uft_pkg;

	// Table size and time width
	localparam int NUM_ENTRIES = 64;
	localparam int TIME_BITS   = 32;
	localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	// Field widths
	localparam int INDEX_W    = 6;
	localparam int COUNT_W    = 16;
	localparam int THRESH_W   = 16;
	localparam int WINDOW_W   = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int CMP_W      = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

	// Queue depths (powers of two, pointers wrap naturally)
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	// Opcodes
	localparam logic OP_MARK_DOWN = 1'b0;
	localparam logic OP_MARK_UP   = 1'b1;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TRIP_LIMIT   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY_WINDOW = 1'd1;

	// Register reset values
	localparam logic [THRESH_W-1:0] TRIP_LIMIT_RST   = 16'd10;
	localparam logic [WINDOW_W-1:0] RETRY_WINDOW_RST = 32'd300;

	// Classified event, front to back
	typedef struct packed {
		logic                 opcode;
		logic [ADDR_W-1:0]    addr;
		logic [INDEX_W-1:0]   index;
		logic                 is_retry;
		logic [TIME_BITS-1:0] now;
		logic                 ignored;
		logic                 in_range;
	} cmd_t;

	// One table entry
	typedef struct packed {
		logic [TIME_BITS-1:0] since;
		logic [COUNT_W-1:0]   count;
		logic                 available;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{since: '0, count: '0, available: 1'b1};

	// One result
	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               available;
		logic [COUNT_W-1:0] failures;
		logic               ignored;
	} res_t;

endpackage
`default_nettype wire

// File: src/upstream_failure_tracker_top.sv
// Top level of the upstream failure tracker.
`default_nettype none
// Upstream failure tracker: a 64-entry health table, one entry per upstream,
// each holding the time of the first failure (zero means clean), a saturating
// 16-bit failure count and an available flag. Every event pushed in yields
// exactly one result item, in order, reporting the entry after the event
// (or as it stood, with ignored set, for events without a valid selection or
// selected through the API). Mark-down stamps or counts failures and clears
// available once the count reaches the trip limit; counting restarts at one
// once more than retry_window seconds have passed since the stamp. A failed
// retry only restamps the time. Mark-up clears the entry and makes it
// available. The back end reads the single-ported table, then updates it in
// its execute state before taking the next item; the front end takes an item
// per cycle until its 2-item queue is full, and a 2-item result queue lets
// the back end keep working while results wait. An accepted item passes the
// command queue, issue and the execute state before empty falls. The user
// writes registers (cfg_index 0: trip limit, 1: retry_window) only while the
// block is idle, not enforced; the table needs no clearing pass after reset.
module upstream_failure_tracker_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// event side
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic                             opcode,
	input  wire logic [uft_pkg::INDEX_W-1:0]      entry_index,
	input  wire logic                             is_retry,
	input  wire logic [31:0]                      now_seconds,
	input  wire logic                             selection_valid,
	input  wire logic                             api_selected,
	// result side
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [uft_pkg::INDEX_W-1:0]           out_index,
	output logic                                  now_available,
	output logic [uft_pkg::COUNT_W-1:0]           failures,
	output logic                                  ignored,
	// settings
	input  wire logic                             cfg_write,
	input  wire logic [uft_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [uft_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic            cmd_valid;
	logic            cmd_pop;
	uft_pkg::cmd_t   cmd_head;
	uft_pkg::res_t   res_head;

	// front: classify and queue items
	uft_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.opcode          (opcode),
		.entry_index     (entry_index),
		.is_retry        (is_retry),
		.now_seconds     (now_seconds),
		.selection_valid (selection_valid),
		.api_selected    (api_selected),
		.cmd_valid       (cmd_valid),
		.cmd_head        (cmd_head),
		.cmd_pop         (cmd_pop)
	);

	// back: table update and result queue
	uft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_empty (empty),
		.res_pop   (pop),
		.res_head  (res_head)
	);

	assign out_index     = res_head.index;
	assign now_available = res_head.available;
	assign failures      = res_head.failures;
	assign ignored       = res_head.ignored;

endmodule
`default_nettype wire

// File: src/uft_front.sv
// Front end: accepts events, classifies them and queues them for the back end.
`default_nettype none
module uft_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         opcode,
	input  wire logic [uft_pkg::INDEX_W-1:0]  entry_index,
	input  wire logic                         is_retry,
	input  wire logic [31:0]                  now_seconds,
	input  wire logic                         selection_valid,
	input  wire logic                         api_selected,
	output logic                              cmd_valid,
	output uft_pkg::cmd_t                     cmd_head,
	input  wire logic                         cmd_pop
);

	uft_pkg::cmd_t                       cmd_in;
	uft_pkg::cmd_t                       q_mem [uft_pkg::CMDQ_DEPTH];
	logic [uft_pkg::CMDQ_PTR_W-1:0]      wr_ptr_q;
	logic [uft_pkg::CMDQ_PTR_W-1:0]      rd_ptr_q;
	logic [uft_pkg::CMDQ_CNT_W-1:0]      cnt_q;
	logic                                push_ok;
	logic                                pop_ok;
	logic                                in_range;

	always_comb begin
		in_range        = (32'(entry_index) < 32'(uft_pkg::NUM_ENTRIES));
		cmd_in.opcode   = opcode;
		cmd_in.addr     = uft_pkg::ADDR_W'(entry_index);
		cmd_in.index    = entry_index;
		cmd_in.is_retry = is_retry;
		cmd_in.now      = uft_pkg::TIME_BITS'(now_seconds);
		cmd_in.ignored  = !selection_valid || api_selected || !in_range;
		cmd_in.in_range = in_range;
	end

	assign full      = (cnt_q == uft_pkg::CMDQ_CNT_W'(uft_pkg::CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;
	assign cmd_head  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/uft_back.sv
// Back end: health table, read-modify-write sequencer, settings and result queue.
`default_nettype none
module uft_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_valid,
	input  wire uft_pkg::cmd_t                    cmd_head,
	output logic                                  cmd_pop,
	input  wire logic                             cfg_write,
	input  wire logic [uft_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [uft_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                  res_empty,
	input  wire logic                             res_pop,
	output uft_pkg::res_t                         res_head
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                              state_q;
	logic [uft_pkg::THRESH_W-1:0]        thresh_q;
	logic [uft_pkg::WINDOW_W-1:0]        window_q;

	uft_pkg::entry_t                     tbl [uft_pkg::NUM_ENTRIES];
	logic [uft_pkg::NUM_ENTRIES-1:0]     written_q;

	uft_pkg::cmd_t                       cmd_s1;
	uft_pkg::entry_t                     rd_s1;
	logic                                hit_s1;

	uft_pkg::entry_t                     cur;
	uft_pkg::entry_t                     nxt;
	logic [uft_pkg::COUNT_W-1:0]         new_count;
	logic [uft_pkg::TIME_BITS-1:0]       elapsed;
	logic                                window_passed;
	logic                                issue;
	logic                                exec;
	logic                                tbl_we;
	uft_pkg::res_t                       res_in;

	uft_pkg::res_t                       res_mem [uft_pkg::RESQ_DEPTH];
	logic [uft_pkg::RESQ_PTR_W-1:0]      res_wr_ptr_q;
	logic [uft_pkg::RESQ_PTR_W-1:0]      res_rd_ptr_q;
	logic [uft_pkg::RESQ_CNT_W-1:0]      res_cnt_q;
	logic                                res_pop_ok;

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= uft_pkg::TRIP_LIMIT_RST;
			window_q <= uft_pkg::RETRY_WINDOW_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				uft_pkg::REG_TRIP_LIMIT:   thresh_q <= cfg_data[uft_pkg::THRESH_W-1:0];
				uft_pkg::REG_RETRY_WINDOW: window_q <= cfg_data[uft_pkg::WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// space is reserved at issue time; the queue only drains meanwhile
	assign issue   = (state_q == ST_IDLE) && cmd_valid &&
			(res_cnt_q != uft_pkg::RESQ_CNT_W'(uft_pkg::RESQ_DEPTH));
	assign exec    = (state_q == ST_EXEC);
	assign cmd_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (issue) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// table read, registered
	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1 <= cmd_head;
			rd_s1  <= tbl[cmd_head.addr];
			hit_s1 <= written_q[cmd_head.addr];
		end
		if (tbl_we) begin
			tbl[cmd_s1.addr] <= nxt;
		end
	end

	// never-written entries read as the reset entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (tbl_we) begin
			written_q[cmd_s1.addr] <= 1'b1;
		end
	end

	// entry update
	always_comb begin
		cur           = hit_s1 ? rd_s1 : uft_pkg::ENTRY_RESET;
		elapsed       = cmd_s1.now - cur.since;
		window_passed = (cmd_s1.now >= cur.since) &&
				(uft_pkg::CMP_W'(elapsed) > uft_pkg::CMP_W'(window_q));
		nxt           = cur;
		new_count     = '0;
		if (cmd_s1.opcode == uft_pkg::OP_MARK_UP) begin
			nxt = uft_pkg::ENTRY_RESET;
		end else begin
			if ((cur.since == '0) || cmd_s1.is_retry) begin
				nxt.since = cmd_s1.now;
				if (!cmd_s1.is_retry) begin
					nxt.count = uft_pkg::COUNT_W'(1);
					new_count = uft_pkg::COUNT_W'(1);
				end
			end else if (window_passed) begin
				nxt.since = cmd_s1.now;
				nxt.count = uft_pkg::COUNT_W'(1);
				new_count = uft_pkg::COUNT_W'(1);
			end else begin
				if (cur.count != '1) begin
					nxt.count = cur.count + 1'b1;
				end
				new_count = nxt.count;
			end
			// failed retry leaves new_count at zero: no threshold test
			if ((new_count != '0) && (new_count >= thresh_q)) begin
				nxt.available = 1'b0;
			end
		end
	end

	assign tbl_we = exec && !cmd_s1.ignored;

	always_comb begin
		res_in.index = cmd_s1.index;
		res_in.ignored = cmd_s1.ignored;
		if (!cmd_s1.in_range) begin
			res_in.available = 1'b0;
			res_in.failures  = '0;
		end else if (cmd_s1.ignored) begin
			res_in.available = cur.available;
			res_in.failures  = cur.count;
		end else begin
			res_in.available = nxt.available;
			res_in.failures  = nxt.count;
		end
	end

	// result queue
	assign res_empty  = (res_cnt_q == '0);
	assign res_pop_ok = res_pop && !res_empty;
	assign res_head   = res_mem[res_rd_ptr_q];

	always_ff @(posedge clk) begin
		if (exec) begin
			res_mem[res_wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= '0;
			res_rd_ptr_q <= '0;
			res_cnt_q    <= '0;
		end else begin
			if (exec) begin
				res_wr_ptr_q <= res_wr_ptr_q + 1'b1;
			end
			if (res_pop_ok) begin
				res_rd_ptr_q <= res_rd_ptr_q + 1'b1;
			end
			if (exec && !res_pop_ok) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_pop_ok && !exec) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
